[rtl/sdcr_pkg.sv]
package sdcr_pkg;

  // Mantissa width that the block computes with (16 to 60).
  localparam int MANT_BITS = 60;
  // Width of the mantissa fields on the ports.
  localparam int FIELD_BITS = 60;
  localparam int SCALE_BITS = 4;
  // Width of the largest power of ten, 10^15.
  localparam int POW_BITS = 50;
  // Dividend width: a magnitude plus half a power of ten always fits.
  localparam int NUM_BITS = ((MANT_BITS > POW_BITS) ? MANT_BITS : POW_BITS) + 1;

  // Largest negative magnitude, 2^(MANT_BITS-1), at dividend width.
  localparam logic [NUM_BITS-1:0] SIGN_MAG = NUM_BITS'(1) << (MANT_BITS - 1);

  typedef enum logic {
    CMD_COMPARE = 1'b0,
    CMD_ROUND   = 1'b1
  } cmd_t;

  // One input word.
  typedef struct packed {
    logic                         command;
    logic signed [FIELD_BITS-1:0] a_mantissa;
    logic        [SCALE_BITS-1:0] a_scale;
    logic signed [FIELD_BITS-1:0] b_mantissa;
    logic        [SCALE_BITS-1:0] b_scale;
    logic        [SCALE_BITS-1:0] round_digits;
  } in_t;

  // One result word.
  typedef struct packed {
    logic signed [FIELD_BITS-1:0] result_mantissa;
    logic        [SCALE_BITS-1:0] result_scale;
    logic                         is_less;
    logic                         is_equal;
    logic                         is_greater;
    logic                         saturated;
  } out_t;

  // Operand facts carried unchanged down the chain.
  typedef struct packed {
    logic                  command;
    logic                  a_neg;
    logic                  b_neg;
    logic [MANT_BITS-1:0]  a_mag;
    logic [MANT_BITS-1:0]  b_mag;
    logic [SCALE_BITS-1:0] a_scale;
    logic                  div_a;
    logic                  round_active;
    logic [NUM_BITS-1:0]   num;
    logic [FIELD_BITS-1:0] res_raw;
  } side_t;

  // Division state: dividend bits shift out at the top, quotient bits in at the bottom.
  typedef struct packed {
    logic [NUM_BITS-1:0] work;
    logic [POW_BITS-1:0] rem;
    logic [POW_BITS-1:0] divisor;
  } div_t;

  typedef struct packed {
    side_t side;
    div_t  div;
  } stage_t;

  // Powers of ten from 10^0 to 10^15.
  function automatic logic [POW_BITS-1:0] pow10(input logic [SCALE_BITS-1:0] idx);
    logic [POW_BITS-1:0] p;
    case (idx)
      4'd0:    p = 50'd1;
      4'd1:    p = 50'd10;
      4'd2:    p = 50'd100;
      4'd3:    p = 50'd1000;
      4'd4:    p = 50'd10000;
      4'd5:    p = 50'd100000;
      4'd6:    p = 50'd1000000;
      4'd7:    p = 50'd10000000;
      4'd8:    p = 50'd100000000;
      4'd9:    p = 50'd1000000000;
      4'd10:   p = 50'd10000000000;
      4'd11:   p = 50'd100000000000;
      4'd12:   p = 50'd1000000000000;
      4'd13:   p = 50'd10000000000000;
      4'd14:   p = 50'd100000000000000;
      4'd15:   p = 50'd1000000000000000;
      default: p = 50'd1;
    endcase
    return p;
  endfunction

endpackage

[rtl/sdcr_cell.sv]
module sdcr_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_stall,
  input  sdcr_pkg::stage_t    up_data,
  output logic                dn_valid,
  input  logic                dn_stall,
  output sdcr_pkg::stage_t    dn_data
);

  logic                              valid;
  sdcr_pkg::stage_t                  data;
  sdcr_pkg::stage_t                  data_next;
  logic [sdcr_pkg::POW_BITS:0]       partial;
  logic                              ge;

  // One restoring division step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    partial   = {up_data.div.rem, up_data.div.work[sdcr_pkg::NUM_BITS-1]};
    ge        = (partial >= {1'b0, up_data.div.divisor});
    data_next = up_data;
    data_next.div.rem  = ge ? sdcr_pkg::POW_BITS'(partial - {1'b0, up_data.div.divisor})
                            : partial[sdcr_pkg::POW_BITS-1:0];
    data_next.div.work = {up_data.div.work[sdcr_pkg::NUM_BITS-2:0], ge};
  end

  // The cell holds its word while the next one stalls.
  assign up_stall = valid && dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

[rtl/sdcr_finish.sv]
module sdcr_finish (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_stall,
  input  sdcr_pkg::stage_t  up_data,
  output logic              res_valid,
  input  logic              res_stall,
  output sdcr_pkg::out_t    res_word
);

  logic                                valid;
  sdcr_pkg::out_t                      word;
  sdcr_pkg::out_t                      word_next;
  logic [sdcr_pkg::NUM_BITS-1:0]       quot;
  logic [sdcr_pkg::NUM_BITS-1:0]       other;
  logic                                q_lt;
  logic                                q_eq;
  logic                                rem_nz;
  logic                                mo_lt;
  logic                                mo_gt;
  logic                                mo_eq;
  logic [sdcr_pkg::NUM_BITS-1:0]       rounded;
  logic [sdcr_pkg::NUM_BITS-1:0]       limit;
  logic                                sat;
  logic [sdcr_pkg::MANT_BITS-1:0]      clamped;

  always_comb begin
    // Magnitude order from the quotient and the remainder of the scaled operand.
    quot   = up_data.div.work;
    other  = up_data.side.div_a ? sdcr_pkg::NUM_BITS'(up_data.side.b_mag)
                                : sdcr_pkg::NUM_BITS'(up_data.side.a_mag);
    q_lt   = quot < other;
    q_eq   = quot == other;
    rem_nz = up_data.div.rem != '0;
    mo_eq  = q_eq && !rem_nz;
    if (up_data.side.div_a) begin
      mo_lt = q_lt;
      mo_gt = (!q_lt && !q_eq) || (q_eq && rem_nz);
    end else begin
      mo_lt = (!q_lt && !q_eq) || (q_eq && rem_nz);
      mo_gt = q_lt;
    end

    // Rounded magnitude is the biased value less its remainder, then clamped.
    rounded = up_data.side.num - sdcr_pkg::NUM_BITS'(up_data.div.rem);
    limit   = up_data.side.a_neg ? sdcr_pkg::SIGN_MAG
                                 : (sdcr_pkg::SIGN_MAG - sdcr_pkg::NUM_BITS'(1));
    sat     = rounded > limit;
    clamped = sat ? limit[sdcr_pkg::MANT_BITS-1:0] : rounded[sdcr_pkg::MANT_BITS-1:0];

    word_next                 = '0;
    word_next.result_scale    = up_data.side.a_scale;
    word_next.result_mantissa = up_data.side.res_raw;
    if (up_data.side.command == sdcr_pkg::CMD_COMPARE) begin
      if (up_data.side.a_neg != up_data.side.b_neg) begin
        word_next.is_less    = up_data.side.a_neg;
        word_next.is_greater = up_data.side.b_neg;
      end else if (up_data.side.a_neg) begin
        word_next.is_less    = mo_gt;
        word_next.is_equal   = mo_eq;
        word_next.is_greater = mo_lt;
      end else begin
        word_next.is_less    = mo_lt;
        word_next.is_equal   = mo_eq;
        word_next.is_greater = mo_gt;
      end
    end else if (up_data.side.round_active) begin
      word_next.saturated = sat;
      if (up_data.side.a_neg && clamped != '0) begin
        word_next.result_mantissa = sdcr_pkg::FIELD_BITS'(0)
                                    - sdcr_pkg::FIELD_BITS'(clamped);
      end else begin
        word_next.result_mantissa = sdcr_pkg::FIELD_BITS'(clamped);
      end
    end
  end

  assign up_stall = valid && res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      word <= word_next;
    end
  end

  assign res_valid = valid;
  assign res_word  = word;

endmodule

[rtl/scaled_decimal_compare_round_unit.sv]
// Channel   Direction  Handshake             Word
// command   in         cmd_valid/cmd_stall   cmd_word (in_t)
// result    out        res_valid/res_stall   res_word (out_t)
//
// One word is taken per cycle while cmd_stall is low; each result passes through
// a preparation stage, one division cell per dividend bit, and the output
// register. Reset is synchronous and empties
// every stage. A stalled result holds its stage only; empty stages further
// up keep filling, so the input stalls only once the chain is full.
module scaled_decimal_compare_round_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  sdcr_pkg::in_t   cmd_word,
  output logic            res_valid,
  input  logic            res_stall,
  output sdcr_pkg::out_t  res_word
);

  localparam int CELLS = sdcr_pkg::NUM_BITS;

  logic [sdcr_pkg::MANT_BITS-1:0]        a_bits;
  logic [sdcr_pkg::MANT_BITS-1:0]        b_bits;
  logic signed [sdcr_pkg::MANT_BITS-1:0] a_low;
  logic [sdcr_pkg::MANT_BITS-1:0]        a_mag;
  logic [sdcr_pkg::MANT_BITS-1:0]        b_mag;
  logic                                  sa_ge_sb;
  logic [sdcr_pkg::SCALE_BITS-1:0]       scale_diff;
  logic [sdcr_pkg::SCALE_BITS-1:0]       pow_idx;
  logic [sdcr_pkg::POW_BITS-1:0]         divisor;
  logic [sdcr_pkg::NUM_BITS-1:0]         dividend;
  sdcr_pkg::stage_t                      prep_next;

  logic                                  prep_valid;
  sdcr_pkg::stage_t                      prep;

  logic [CELLS:0]                        chain_valid;
  logic [CELLS:0]                        chain_stall;
  sdcr_pkg::stage_t                      chain_data [CELLS+1];

  // Preparation: signs, magnitudes, the power of ten and the dividend.
  always_comb begin
    a_bits     = cmd_word.a_mantissa[sdcr_pkg::MANT_BITS-1:0];
    b_bits     = cmd_word.b_mantissa[sdcr_pkg::MANT_BITS-1:0];
    a_low      = a_bits;
    a_mag      = a_bits[sdcr_pkg::MANT_BITS-1] ? (~a_bits + 1'b1) : a_bits;
    b_mag      = b_bits[sdcr_pkg::MANT_BITS-1] ? (~b_bits + 1'b1) : b_bits;
    sa_ge_sb   = cmd_word.a_scale >= cmd_word.b_scale;
    scale_diff = sa_ge_sb ? (cmd_word.a_scale - cmd_word.b_scale)
                          : (cmd_word.b_scale - cmd_word.a_scale);

    prep_next                   = '0;
    prep_next.side.command      = cmd_word.command;
    prep_next.side.a_neg        = a_bits[sdcr_pkg::MANT_BITS-1];
    prep_next.side.b_neg        = b_bits[sdcr_pkg::MANT_BITS-1];
    prep_next.side.a_mag        = a_mag;
    prep_next.side.b_mag        = b_mag;
    prep_next.side.a_scale      = cmd_word.a_scale;
    prep_next.side.div_a        = sa_ge_sb;
    prep_next.side.round_active = cmd_word.round_digits < cmd_word.a_scale;
    prep_next.side.res_raw      = sdcr_pkg::FIELD_BITS'(a_low);

    if (cmd_word.command == sdcr_pkg::CMD_ROUND) begin
      pow_idx = cmd_word.a_scale - cmd_word.round_digits;
    end else begin
      pow_idx = scale_diff;
    end
    divisor = sdcr_pkg::pow10(pow_idx);

    // Round divides a biased by half a unit; compare divides the larger-scale operand.
    if (cmd_word.command == sdcr_pkg::CMD_ROUND) begin
      if (prep_next.side.round_active) begin
        dividend = sdcr_pkg::NUM_BITS'(a_mag) + sdcr_pkg::NUM_BITS'(divisor >> 1);
      end else begin
        dividend = '0;
      end
    end else begin
      dividend = sa_ge_sb ? sdcr_pkg::NUM_BITS'(a_mag) : sdcr_pkg::NUM_BITS'(b_mag);
    end

    prep_next.side.num    = dividend;
    prep_next.div.work    = dividend;
    prep_next.div.rem     = '0;
    prep_next.div.divisor = divisor;
  end

  assign cmd_stall = prep_valid && chain_stall[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (!cmd_stall) begin
      prep_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      prep <= prep_next;
    end
  end

  assign chain_valid[0] = prep_valid;
  assign chain_data[0]  = prep;

  // Row of division cells, one quotient bit each.
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    sdcr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[g]),
      .up_stall (chain_stall[g]),
      .up_data  (chain_data[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_stall (chain_stall[g+1]),
      .dn_data  (chain_data[g+1])
    );
  end

  sdcr_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (chain_valid[CELLS]),
    .up_stall  (chain_stall[CELLS]),
    .up_data   (chain_data[CELLS]),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule
